### design/ubo_pkg.sv
// Shared types, widths and codes of the uniform block offset allocator.
package ubo_pkg;

  // Width of the running byte offset and of the array length field.
  localparam int OFFSET_BITS = 16;
  localparam int COUNT_BITS  = 10;
  // Alignments go up to 256 bytes.
  localparam int ALIGN_BITS  = 9;
  // A padded struct size (17 bits) times the array length.
  localparam int SIZE_BITS   = COUNT_BITS + 17;
  // Aligned start plus size, with one bit of headroom for the overflow check.
  localparam int SUM_BITS    = ((OFFSET_BITS + 1) > SIZE_BITS ?
                                (OFFSET_BITS + 1) : SIZE_BITS) + 1;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_FIELD_BITS  = 3 + 3 + 1 + COUNT_BITS + 16 + ALIGN_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * OFFSET_BITS + ALIGN_BITS + 1;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Input tdata bit positions, lowest field first.
  localparam int VLEN_LSB   = 0;
  localparam int MCOLS_LSB  = 3;
  localparam int FULL_LSB   = 6;
  localparam int COUNT_LSB  = 7;
  localparam int SSIZE_LSB  = COUNT_LSB + COUNT_BITS;
  localparam int SALIGN_LSB = SSIZE_LSB + 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ARRAYS_AS_VEC4       = 2'd0;
  localparam logic [1:0] CFG_PAD_VEC3             = 2'd1;
  localparam logic [1:0] CFG_FORCE_FULL_PRECISION = 2'd2;

  // Command codes carried on tuser.
  typedef enum logic [1:0] {
    CMD_FIELD   = 2'd0,
    CMD_STRUCT  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  // Layout flags.
  typedef struct packed {
    logic arrays_as_vec4;
    logic pad_vec3;
    logic force_full_precision;
  } cfg_t;

  // One request's fields apart from the command.
  typedef struct packed {
    logic [2:0]            vector_length;
    logic [2:0]            matrix_columns;
    logic                  full_precision_type;
    logic [COUNT_BITS-1:0] element_count;
    logic [15:0]           struct_size;
    logic [ALIGN_BITS-1:0] struct_alignment;
  } item_t;

  // A request reduced to its alignment and byte size.
  typedef struct packed {
    cmd_e                  cmd;
    logic [ALIGN_BITS-1:0] align;
    logic [SIZE_BITS-1:0]  size;
  } dec_t;

  // One result.
  typedef struct packed {
    logic [OFFSET_BITS-1:0] placed_offset;
    logic [OFFSET_BITS-1:0] next_offset;
    logic [ALIGN_BITS-1:0]  required_alignment;
    logic                   overflow;
  } res_t;

endpackage

### design/ubo_decode.sv
// Turns a field or struct request into its alignment and byte size.
module ubo_decode (
  input  ubo_pkg::cmd_e  cmd_i,
  input  ubo_pkg::item_t item_i,
  input  ubo_pkg::cfg_t  cfg_i,
  output ubo_pkg::dec_t  dec_o
);
  import ubo_pkg::*;

  // Next power of two, with 0 taken as 1 and a ceiling of 256.
  function automatic logic [ALIGN_BITS-1:0] pow2_ceil(input logic [ALIGN_BITS-1:0] v);
    logic [7:0] m;
    m = 8'(v - 9'd1);
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    if (v <= 9'd1) begin
      return 9'd1;
    end else if (v > 9'd256) begin
      return 9'd256;
    end
    return {1'b0, m} + 9'd1;
  endfunction

  logic                  is_mat;
  logic                  is_array;
  logic [2:0]            dim_m;
  logic [2:0]            dim_v;
  logic [2:0]            dim;
  logic [2:0]            fdim;
  logic [2:0]            mat_mul;
  logic [4:0]            dim_prod;
  logic                  prim4;
  logic [6:0]            field_unit;
  logic [ALIGN_BITS-1:0] falign_base;
  logic [ALIGN_BITS-1:0] falign;
  logic [ALIGN_BITS-1:0] salign;
  logic [ALIGN_BITS-1:0] smask;
  logic [16:0]           spadded;
  logic [COUNT_BITS-1:0] cnt_n;
  logic [16:0]           op_a;

  always_comb begin
    // Clamp the vector length and matrix size into 1..4.
    dim_m  = (item_i.matrix_columns > 3'd4) ? 3'd4 : item_i.matrix_columns;
    if (item_i.vector_length == 3'd0) begin
      dim_v = 3'd1;
    end else if (item_i.vector_length > 3'd4) begin
      dim_v = 3'd4;
    end else begin
      dim_v = item_i.vector_length;
    end
    is_mat   = (item_i.matrix_columns != 3'd0);
    dim      = is_mat ? dim_m : dim_v;
    // A matrix is always an array of column vectors.
    is_array = is_mat || (item_i.element_count != '0);
    if ((is_array && cfg_i.arrays_as_vec4) ||
        ((dim == 3'd3) && (is_array || cfg_i.pad_vec3))) begin
      fdim = 3'd4;
    end else begin
      fdim = dim;
    end
    prim4 = cfg_i.force_full_precision || item_i.full_precision_type;

    // Bytes per array element; a matrix element counts all its columns.
    mat_mul    = is_mat ? dim_m : 3'd1;
    dim_prod   = 5'(fdim) * 5'(mat_mul);
    field_unit = prim4 ? {dim_prod, 2'b00} : {1'b0, dim_prod, 1'b0};

    // Field alignment is the padded dimension rounded to a power of two, times the 2 or 4 byte component size.
    case (fdim)
      3'd1:    falign_base = 9'd1;
      3'd2:    falign_base = 9'd2;
      default: falign_base = 9'd4;
    endcase
    falign = prim4 ? (falign_base << 2) : (falign_base << 1);

    // Struct size is padded up to its base alignment.
    salign  = pow2_ceil(item_i.struct_alignment);
    smask   = salign - 9'd1;
    spadded = ({1'b0, item_i.struct_size} + {8'b0, smask}) & ~{8'b0, smask};

    cnt_n = (item_i.element_count == '0) ? COUNT_BITS'(1) : item_i.element_count;
    op_a  = (cmd_i == CMD_STRUCT) ? spadded : {10'b0, field_unit};

    dec_o.cmd   = cmd_i;
    dec_o.align = (cmd_i == CMD_STRUCT) ? salign : falign;
    dec_o.size  = SIZE_BITS'(op_a) * SIZE_BITS'(cnt_n);
  end

endmodule

### design/ubo_place.sv
// Aligns the running offset, advances it and tracks the largest alignment.
module ubo_place (
  input  ubo_pkg::dec_t                        dec_i,
  input  logic [ubo_pkg::OFFSET_BITS-1:0]      running_i,
  input  logic [ubo_pkg::ALIGN_BITS-1:0]       max_align_i,
  output ubo_pkg::res_t                        res_o,
  output logic [ubo_pkg::OFFSET_BITS-1:0]      running_o,
  output logic [ubo_pkg::ALIGN_BITS-1:0]       max_align_o
);
  import ubo_pkg::*;

  logic [ALIGN_BITS-1:0]  mask;
  logic [OFFSET_BITS:0]   mask_ext;
  logic [OFFSET_BITS:0]   start_al;
  logic [SUM_BITS-1:0]    end_sum;
  logic                   start_ovf;
  logic                   end_ovf;
  logic [OFFSET_BITS-1:0] start_sat;
  logic [OFFSET_BITS-1:0] end_sat;
  logic [ALIGN_BITS-1:0]  max_new;

  always_comb begin
    // Align up, then add the size; both saturate at the top of the range.
    mask      = dec_i.align - 9'd1;
    mask_ext  = (OFFSET_BITS+1)'(mask);
    start_al  = ({1'b0, running_i} + mask_ext) & ~mask_ext;
    end_sum   = SUM_BITS'(start_al) + SUM_BITS'(dec_i.size);
    start_ovf = start_al[OFFSET_BITS];
    end_ovf   = (end_sum[SUM_BITS-1:OFFSET_BITS] != '0);
    start_sat = start_ovf ? '1 : start_al[OFFSET_BITS-1:0];
    end_sat   = end_ovf ? '1 : end_sum[OFFSET_BITS-1:0];
    max_new   = (dec_i.align > max_align_i) ? dec_i.align : max_align_i;

    case (dec_i.cmd)
      CMD_RESTART: begin
        res_o       = '0;
        running_o   = '0;
        max_align_o = '0;
      end
      CMD_QUERY: begin
        res_o.placed_offset      = running_i;
        res_o.next_offset        = running_i;
        res_o.required_alignment = max_align_i;
        res_o.overflow           = 1'b0;
        running_o                = running_i;
        max_align_o              = max_align_i;
      end
      default: begin
        res_o.placed_offset      = start_sat;
        res_o.next_offset        = end_sat;
        res_o.required_alignment = max_new;
        res_o.overflow           = start_ovf || end_ovf;
        running_o                = end_sat;
        max_align_o              = max_new;
      end
    endcase
  end

endmodule

### design/uniform_block_offset_allocator.sv
// A request is registered in the input stage, then the decode stage, then the result register that drives the output.
// One request per cycle while the result stream is not stalled; the offset update is a single registered step.
// The placement stage reads and writes the running offset in the same cycle.
// Reset clears the running offset, the largest alignment, the layout flags
// and all stage valids; payload registers are not reset.
module uniform_block_offset_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Layout flag writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic                                cfg_data_i,
  // Requests.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // vector_length[2:0], matrix_columns[2:0], full_precision_type,
  // element_count[COUNT_BITS-1:0], struct_size[15:0], struct_alignment[8:0], zero fill
  input  logic [ubo_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata_i,
  // command[1:0]
  input  logic [1:0]                          s_axis_tuser_i,
  // Results.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // placed_offset, next_offset, required_alignment[8:0], overflow, zero fill
  output logic [ubo_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata_o
);
  import ubo_pkg::*;

  cfg_t                   cfg_q;
  logic                   in_valid_q;
  cmd_e                   in_cmd_q;
  item_t                  in_item_q;
  logic                   dec_valid_q;
  dec_t                   dec_q;
  dec_t                   dec_d;
  logic                   out_valid_q;
  res_t                   res_q;
  res_t                   res_d;
  logic [OFFSET_BITS-1:0] running_q;
  logic [OFFSET_BITS-1:0] running_d;
  logic [ALIGN_BITS-1:0]  max_align_q;
  logic [ALIGN_BITS-1:0]  max_align_d;
  item_t                  item_in;
  logic                   out_ready;
  logic                   dec_ready;
  logic                   in_ready;
  logic                   in_fire;
  logic                   in_adv;
  logic                   dec_adv;

  // Unpack the request payload.
  always_comb begin
    item_in.vector_length       = s_axis_tdata_i[VLEN_LSB +: 3];
    item_in.matrix_columns      = s_axis_tdata_i[MCOLS_LSB +: 3];
    item_in.full_precision_type = s_axis_tdata_i[FULL_LSB];
    item_in.element_count       = s_axis_tdata_i[COUNT_LSB +: COUNT_BITS];
    item_in.struct_size         = s_axis_tdata_i[SSIZE_LSB +: 16];
    item_in.struct_alignment    = s_axis_tdata_i[SALIGN_LSB +: ALIGN_BITS];
  end

  // Each stage moves on when the stage after it is empty or moving.
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign dec_ready       = !dec_valid_q || out_ready;
  assign in_ready        = !in_valid_q || dec_ready;
  assign in_fire         = s_axis_tvalid_i && in_ready;
  assign in_adv          = in_valid_q && dec_ready;
  assign dec_adv         = dec_valid_q && out_ready;
  assign s_axis_tready_o = in_ready;
  assign cfg_ready_o     = 1'b1;

  ubo_decode u_decode (
    .cmd_i  (in_cmd_q),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .dec_o  (dec_d)
  );

  ubo_place u_place (
    .dec_i       (dec_q),
    .running_i   (running_q),
    .max_align_i (max_align_q),
    .res_o       (res_d),
    .running_o   (running_d),
    .max_align_o (max_align_d)
  );

  // Control state: valids, running offset, largest alignment and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      dec_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      running_q   <= '0;
      max_align_q <= '0;
      cfg_q       <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (dec_ready) begin
        dec_valid_q <= in_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= dec_valid_q;
      end
      if (dec_adv) begin
        running_q   <= running_d;
        max_align_q <= max_align_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ARRAYS_AS_VEC4:       cfg_q.arrays_as_vec4       <= cfg_data_i;
          CFG_PAD_VEC3:             cfg_q.pad_vec3             <= cfg_data_i;
          CFG_FORCE_FULL_PRECISION: cfg_q.force_full_precision <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser_i);
      in_item_q <= item_in;
    end
    if (in_adv) begin
      dec_q <= dec_d;
    end
    if (dec_adv) begin
      res_q <= res_d;
    end
  end

  // Pack the result payload.
  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[OUT_FIELD_BITS-1:0] = {res_q.overflow, res_q.required_alignment,
                                          res_q.next_offset, res_q.placed_offset};
  end
  assign m_axis_tvalid_o = out_valid_q;

endmodule
